FILE: hdl/ptree_pkg.sv
// ----------------------------------------------------------------------------
// ptree_pkg
// shared types and constants for the palindromic tree append block
// ----------------------------------------------------------------------------
`default_nettype none

package ptree_pkg;

    localparam int SYM_W   = 5;
    localparam int FIELD_W = 11;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_WADDR = 11'b000_0000_0100,
        S_WPOS  = 11'b000_0000_1000,
        S_WCMP  = 11'b000_0001_0000,
        S_EMUL  = 11'b000_0010_0000,
        S_ERD   = 11'b000_0100_0000,
        S_EUSE  = 11'b000_1000_0000,
        S_QRD   = 11'b001_0000_0000,
        S_QUSE  = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } ptree_state_t;

endpackage

`default_nettype wire

FILE: hdl/ptree_ram.sv
// ----------------------------------------------------------------------------
// ptree_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ptree_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/palindromic_tree_append.sv
// ----------------------------------------------------------------------------
// palindromic_tree_append
// online palindromic tree: appends one symbol per item and reports the
// longest palindromic suffix node with its counts
// ----------------------------------------------------------------------------
//  channel | ports               | contents
//  input   | s_tvalid/tready     | tdata: symbol
//  result  | m_tvalid/tready     | tdata: node_id..longest_seen, tuser: overflow
//
//  an item takes one or two walks of suffix link steps (length read, text
//  read, compare; the text read is skipped when the mirrored position falls
//  before the text), plus accept, edge and node lookup and result write;
//  a dropped symbol goes straight from accept to result write
//  after reset the edge store is cleared, one entry a cycle, all
//  (MAX_TEXT+2)*ALPHABET entries, before the first item is taken
//  a waiting result does not stop the next item being taken; that item
//  stalls in its last cycle until the waiting result has been taken
`default_nettype none

module palindromic_tree_append
    import ptree_pkg::*;
#(
    parameter int ALPHABET = 26,
    parameter int MAX_TEXT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // symbol[4:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // node_id, pal_length, end_count,
                                        // distinct_total, longest_seen
    output logic      [0:0]  m_tuser    // overflow
);

    localparam int NODE_CAP = MAX_TEXT + 2;
    localparam int TL_W     = $clog2(MAX_TEXT + 1);
    localparam int LEN_W    = TL_W + 1;
    localparam int POS_W    = TL_W + 2;
    localparam int TA_W     = $clog2(MAX_TEXT);
    localparam int NODE_W   = $clog2(NODE_CAP);
    localparam int NT_W     = $clog2(NODE_CAP + 1);
    localparam int EDEPTH   = NODE_CAP * ALPHABET;
    localparam int EA_W     = $clog2(EDEPTH);

    ptree_state_t state_reg, state_next;

    logic [TL_W-1:0]         tl_reg, tl_next;
    logic [NT_W-1:0]         nt_reg, nt_next;
    logic [NODE_W-1:0]       last_reg, last_next;
    logic [TL_W-1:0]         last_len_reg, last_len_next;
    logic [TL_W-1:0]         last_hits_reg, last_hits_next;
    logic [TL_W-1:0]         max_reg, max_next;
    logic [SYM_W-1:0]        sym_reg, sym_next;
    logic [NODE_W-1:0]       p_reg, p_next;
    logic signed [LEN_W-1:0] plen_reg, plen_next;
    logic [NODE_W-1:0]       plink_reg, plink_next;
    logic                    mode_reg, mode_next;
    logic [EA_W-1:0]         idx_reg, idx_next;
    logic [NODE_W-1:0]       q_reg, q_next;
    logic [TL_W-1:0]         qlen_reg, qlen_next;
    logic [TL_W-1:0]         hnew_reg, hnew_next;
    logic                    flag_reg, flag_next;
    logic [EA_W-1:0]         clr_reg, clr_next;
    logic                    mv_reg, mv_next;
    logic [55:0]             md_reg, md_next;
    logic                    mu_reg, mu_next;

    logic                    txt_we;
    logic [TA_W-1:0]         txt_waddr, txt_raddr;
    logic [SYM_W-1:0]        txt_rd;
    logic                    len_we;
    logic [NODE_W-1:0]       len_raddr;
    logic [TL_W-1:0]         len_wdata, len_rd;
    logic                    lnk_we;
    logic [NODE_W-1:0]       lnk_waddr;
    logic [NODE_W-1:0]       lnk_wdata, lnk_rd;
    logic                    hit_we;
    logic [TL_W-1:0]         hit_rd;
    logic                    edg_we;
    logic [EA_W-1:0]         edg_waddr;
    logic [NODE_W-1:0]       edg_wdata, edg_rd;

    logic signed [LEN_W-1:0] lenv, newlen;
    logic [NODE_W-1:0]       linkv;
    logic signed [POS_W-1:0] pos;
    logic                    accept, drop;
    logic [NODE_W-1:0]       o_node;
    logic [TL_W-1:0]         o_len, o_hits, o_max;

    assign accept = s_tvalid && s_tready;
    assign drop   = (9'(s_tdata[SYM_W-1:0]) >= 9'(ALPHABET)) || (32'(tl_reg) >= MAX_TEXT)
                 || (32'(nt_reg) >= NODE_CAP);

    assign lenv  = (p_reg == '0) ? -LEN_W'(1) :
                   (p_reg == NODE_W'(1)) ? '0 : $signed({1'b0, len_rd});
    assign linkv = (p_reg < NODE_W'(2)) ? '0 : lnk_rd;
    assign pos   = $signed({2'b00, tl_reg}) - POS_W'(1) - POS_W'(lenv);
    assign newlen = plen_reg + LEN_W'(2);

    assign txt_raddr = TA_W'(pos - POS_W'(1));
    assign len_raddr = (state_reg == S_QRD) ? q_reg : p_reg;

    // new node is still at nt_reg on the first walk, in q_reg on the second
    assign lnk_waddr = mode_reg ? q_reg : NODE_W'(nt_reg);

    assign o_node = flag_reg ? last_reg : q_reg;
    assign o_len  = flag_reg ? last_len_reg : qlen_reg;
    assign o_hits = flag_reg ? last_hits_reg : hnew_reg;
    assign o_max  = (!flag_reg && qlen_reg > max_reg) ? qlen_reg : max_reg;

    always_comb begin
        state_next     = state_reg;
        tl_next        = tl_reg;
        nt_next        = nt_reg;
        last_next      = last_reg;
        last_len_next  = last_len_reg;
        last_hits_next = last_hits_reg;
        max_next       = max_reg;
        sym_next       = sym_reg;
        p_next         = p_reg;
        plen_next      = plen_reg;
        plink_next     = plink_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        q_next         = q_reg;
        qlen_next      = qlen_reg;
        hnew_next      = hnew_reg;
        flag_next      = flag_reg;
        clr_next       = clr_reg;
        mv_next        = mv_reg;
        md_next        = md_reg;
        mu_next        = mu_reg;
        txt_we         = 1'b0;
        txt_waddr      = TA_W'(tl_reg);
        len_we         = 1'b0;
        len_wdata      = TL_W'(newlen);
        lnk_we         = 1'b0;
        lnk_wdata      = edg_rd;
        hit_we         = 1'b0;
        edg_we         = 1'b0;
        edg_waddr      = idx_reg;
        edg_wdata      = NODE_W'(nt_reg);
        s_tready       = 1'b0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                edg_we    = 1'b1;
                edg_waddr = clr_reg;
                edg_wdata = '0;
                clr_next  = clr_reg + EA_W'(1);
                if (clr_reg == EA_W'(EDEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    sym_next = s_tdata[SYM_W-1:0];
                    if (drop) begin
                        flag_next  = 1'b1;
                        state_next = S_FIN;
                    end else begin
                        txt_we     = 1'b1;
                        tl_next    = tl_reg + TL_W'(1);
                        p_next     = last_reg;
                        mode_next  = 1'b0;
                        flag_next  = 1'b0;
                        state_next = S_WADDR;
                    end
                end
            end
            S_WADDR: begin
                state_next = S_WPOS;
            end
            S_WPOS: begin
                plen_next  = lenv;
                plink_next = linkv;
                if (pos < POS_W'(1)) begin
                    p_next     = linkv;
                    state_next = S_WADDR;
                end else begin
                    state_next = S_WCMP;
                end
            end
            S_WCMP: begin
                if (txt_rd == sym_reg) begin
                    state_next = S_EMUL;
                end else begin
                    p_next     = plink_reg;
                    state_next = S_WADDR;
                end
            end
            S_EMUL: begin
                idx_next   = EA_W'(EA_W'(p_reg) * EA_W'(ALPHABET)) + EA_W'(sym_reg);
                state_next = S_ERD;
            end
            S_ERD: begin
                state_next = S_EUSE;
            end
            S_EUSE: begin
                if (mode_reg) begin
                    lnk_we     = 1'b1;
                    lnk_wdata  = edg_rd;
                    state_next = S_FIN;
                end else if (edg_rd != '0) begin
                    q_next     = edg_rd;
                    state_next = S_QRD;
                end else begin
                    q_next    = NODE_W'(nt_reg);
                    nt_next   = nt_reg + NT_W'(1);
                    qlen_next = TL_W'(newlen);
                    hnew_next = TL_W'(1);
                    len_we    = 1'b1;
                    edg_we    = 1'b1;
                    if (newlen == LEN_W'(1)) begin
                        lnk_we     = 1'b1;
                        lnk_wdata  = NODE_W'(1);
                        state_next = S_FIN;
                    end else begin
                        mode_next  = 1'b1;
                        p_next     = plink_reg;
                        state_next = S_WADDR;
                    end
                end
            end
            S_QRD: begin
                state_next = S_QUSE;
            end
            S_QUSE: begin
                qlen_next  = len_rd;
                hnew_next  = hit_rd + TL_W'(1);
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!mv_reg || m_tready) begin
                    if (!flag_reg) begin
                        hit_we         = 1'b1;
                        last_next      = q_reg;
                        last_len_next  = qlen_reg;
                        last_hits_next = hnew_reg;
                        max_next       = o_max;
                    end
                    mv_next    = 1'b1;
                    md_next    = {1'b0, FIELD_W'(o_max), FIELD_W'(nt_reg - NT_W'(2)),
                                  FIELD_W'(o_hits), FIELD_W'(o_len), FIELD_W'(o_node)};
                    mu_next    = flag_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            tl_reg        <= '0;
            nt_reg        <= NT_W'(2);
            last_reg      <= NODE_W'(1);
            last_len_reg  <= '0;
            last_hits_reg <= '0;
            max_reg       <= '0;
            clr_reg       <= '0;
            mv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tl_reg        <= tl_next;
            nt_reg        <= nt_next;
            last_reg      <= last_next;
            last_len_reg  <= last_len_next;
            last_hits_reg <= last_hits_next;
            max_reg       <= max_next;
            clr_reg       <= clr_next;
            mv_reg        <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg   <= sym_next;
        p_reg     <= p_next;
        plen_reg  <= plen_next;
        plink_reg <= plink_next;
        mode_reg  <= mode_next;
        idx_reg   <= idx_next;
        q_reg     <= q_next;
        qlen_reg  <= qlen_next;
        hnew_reg  <= hnew_next;
        flag_reg  <= flag_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    ptree_ram #(.WIDTH(SYM_W), .DEPTH(MAX_TEXT)) u_text (
        .aclk (aclk), .we (txt_we), .waddr (txt_waddr), .wdata (s_tdata[SYM_W-1:0]),
        .raddr (txt_raddr), .rdata (txt_rd)
    );

    ptree_ram #(.WIDTH(TL_W), .DEPTH(NODE_CAP)) u_len (
        .aclk (aclk), .we (len_we), .waddr (NODE_W'(nt_reg)), .wdata (len_wdata),
        .raddr (len_raddr), .rdata (len_rd)
    );

    ptree_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_link (
        .aclk (aclk), .we (lnk_we), .waddr (lnk_waddr), .wdata (lnk_wdata),
        .raddr (p_reg), .rdata (lnk_rd)
    );

    ptree_ram #(.WIDTH(TL_W), .DEPTH(NODE_CAP)) u_hits (
        .aclk (aclk), .we (hit_we), .waddr (q_reg), .wdata (hnew_reg),
        .raddr (q_reg), .rdata (hit_rd)
    );

    ptree_ram #(.WIDTH(NODE_W), .DEPTH(EDEPTH)) u_edge (
        .aclk (aclk), .we (edg_we), .waddr (edg_waddr), .wdata (edg_wdata),
        .raddr (idx_reg), .rdata (edg_rd)
    );

endmodule

`default_nettype wire

FILE: hdl/ptree_checker.sv
// ----------------------------------------------------------------------------
// ptree_checker
// port level checks for the palindromic tree append block
// ----------------------------------------------------------------------------
`default_nettype none

module ptree_checker
    import ptree_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    a_reset_not_ready : assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("ready straight after reset");

    a_one_at_a_time : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");

    a_result_held : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_len_in_max : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*FIELD_W-1:FIELD_W] <= m_tdata[5*FIELD_W-1:4*FIELD_W]))
        else $error("suffix length above longest seen");

    a_hits_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[3*FIELD_W-1:2*FIELD_W] != '0))
        else $error("appended item with zero end count");

endmodule

bind palindromic_tree_append ptree_checker u_ptree_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for palindromic_tree_append: symbols stream in, each
// item is predicted by a local eertree and the result fields are compared
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ptree_pkg::*;

    localparam int ALPHA    = 26;
    localparam int TEXT_MAX = 1024;
    localparam int NODES    = TEXT_MAX + 2;
    localparam int WDOG_MAX = (TEXT_MAX + 2) * ALPHA + 200000;

    typedef struct packed {
        logic [10:0] node_id;
        logic [10:0] pal_length;
        logic [10:0] end_count;
        logic [10:0] distinct_total;
        logic [10:0] longest_seen;
        logic        overflow;
    } append_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;

    palindromic_tree_append dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // local eertree
    logic [4:0]  txt [TEXT_MAX];
    int          txt_len;
    int          nlen [NODES];
    int          slink [NODES];
    int          hits [NODES];
    int          edges [NODES*ALPHA];
    int          ntotal;
    int          lastn;
    int          maxlen;

    append_res_t expected_q[$];
    int          errors;
    int          n_sent;
    int          n_got;
    int          n_ovf;
    int          idle_cnt;
    int          hold_cnt;
    bit          done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int walk(int p, int x);
        int pos;
        forever begin
            pos = txt_len - 1 - nlen[p];
            if (pos >= 1 && pos <= txt_len && txt[pos-1] == x)
                return p;
            if (p == 0)
                return 0;
            p = slink[p];
        end
    endfunction

    function automatic append_res_t eertree_append(logic [4:0] x);
        append_res_t r;
        int p, q, s;
        bit drop;
        drop = (x >= ALPHA) || (txt_len >= TEXT_MAX) || (ntotal >= NODES);
        if (!drop) begin
            txt[txt_len] = x;
            txt_len++;
            p = walk(lastn, x);
            q = edges[p*ALPHA + x];
            if (q == 0) begin
                q = ntotal;
                ntotal++;
                nlen[q] = nlen[p] + 2;
                hits[q] = 0;
                edges[p*ALPHA + x] = q;
                if (nlen[q] == 1) begin
                    slink[q] = 1;
                end else begin
                    s = walk(slink[p], x);
                    slink[q] = edges[s*ALPHA + x];
                end
            end
            lastn = q;
            hits[q]++;
            if (nlen[q] > maxlen)
                maxlen = nlen[q];
        end
        r.node_id        = 11'(lastn);
        r.pal_length     = 11'(nlen[lastn] < 0 ? 0 : nlen[lastn]);
        r.end_count      = 11'(hits[lastn]);
        r.distinct_total = 11'(ntotal - 2);
        r.longest_seen   = 11'(maxlen);
        r.overflow       = drop;
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_symbol(logic [7:0] sym);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (g) @(posedge aclk);
        end
        expected_q = {expected_q, eertree_append(sym[4:0])};
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        append_res_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            idle_cnt = 0;
            got = '{m_tdata[10:0], m_tdata[21:11], m_tdata[32:22], m_tdata[43:33],
                    m_tdata[54:44], m_tuser[0]};
            n_got++;
            if (got.overflow)
                n_ovf++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    $display("%0t mismatch exp node %0d len %0d cnt %0d dist %0d max %0d ovf %0d",
                             $time, exp_r.node_id, exp_r.pal_length, exp_r.end_count,
                             exp_r.distinct_total, exp_r.longest_seen, exp_r.overflow);
                    $display("%0t          act node %0d len %0d cnt %0d dist %0d max %0d ovf %0d",
                             $time, got.node_id, got.pal_length, got.end_count,
                             got.distinct_total, got.longest_seen, got.overflow);
                    errors++;
                end
            end
        end else if (s_tvalid && s_tready) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (aresetn) begin
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 3) begin
                hold_cnt = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 9) > 1);
            end
        end
        if (idle_cnt >= WDOG_MAX && !done) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        logic [7:0] seq [$];
        seq = '{8'd0, 8'd0, 8'd0, 8'd25, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1,
                8'd26, 8'd31, 8'd25, 8'd1, 8'd0, 8'd1, 8'd2, 8'd2, 8'd1, 8'd0,
                8'd255};
        foreach (seq[i])
            send_symbol(seq[i]);
        drain();
    endtask

    task automatic test_random();
        int k, len, m;
        logic [7:0] run [$];
        while (txt_len < 410) begin
            k = $urandom_range(0, 99);
            if (k < 55) begin
                // palindromic chunk over an alphabet of 2 to 26 symbols
                len = $urandom_range(1, 8);
                m = $urandom_range(2, 26);
                run = {};
                for (int i = 0; i < len; i++)
                    run = {run, 8'($urandom_range(0, m - 1))};
                foreach (run[i])
                    send_symbol(run[i]);
                for (int i = len - 1 - $urandom_range(0, 1); i >= 0; i--)
                    send_symbol(run[i]);
            end else if (k < 95) begin
                send_symbol(8'($urandom_range(0, 25)));
            end else begin
                send_symbol(8'($urandom_range(26, 255)));
            end
        end
        drain();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        errors = 0; n_sent = 0; n_got = 0; n_ovf = 0; idle_cnt = 0; hold_cnt = 0;
        done = 0;
        txt_len = 0; ntotal = 2; lastn = 1; maxlen = 0;
        for (int i = 0; i < NODES; i++) begin
            nlen[i] = 0; slink[i] = 0; hits[i] = 0;
        end
        foreach (edges[i])
            edges[i] = 0;
        nlen[0] = -1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        done = 1;
        $display("%0d items sent, %0d results checked, %0d dropped symbols", n_sent, n_got, n_ovf);
        $display("text filled to %0d, %0d distinct palindromes, longest %0d",
                 txt_len, ntotal - 2, maxlen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
